### rtl/bc7e_pkg.sv
// Shared types and constants of the BC7 mode-6 solid block encoder.
`timescale 1ns / 1ps

package bc7e_pkg;

   // Widths of the colour channels, the tile sums and the position count.
   localparam int CHAN_W     = 8;
   localparam int SUM_W      = 12;
   localparam int CNT_W      = 5;
   localparam int ENDPOINT_W = 7;

   // Number of positions in one 4x4 tile; further inside positions are dropped.
   localparam logic [CNT_W-1:0] TILE_POSITIONS = CNT_W'(16);

   // Fixed fields of a mode-6 block.
   localparam logic [ENDPOINT_W-1:0] MODE6_BITS     = 7'h40;
   localparam logic [ENDPOINT_W-1:0] ALPHA_ENDPOINT = 7'h7F;

   // Default number of finished tiles that may wait between front and back.
   localparam int QUEUE_DEPTH = 2;

   // Totals of one finished tile, handed from the front to the back.
   typedef struct packed {
      logic [SUM_W-1:0] red_sum;
      logic [SUM_W-1:0] green_sum;
      logic [SUM_W-1:0] blue_sum;
      logic [CNT_W-1:0] count;
   } tile_sums_type;

endpackage

### rtl/bc7_solid_block_encoder_top.sv
// Top level of the BC7 mode-6 solid block encoder.
`timescale 1ns / 1ps
//
// The req_ channel takes the sixteen positions of a 4x4 tile, one transfer
// each: colour in req_tdata, the inside-image flag in req_tuser and the last
// position of the tile on req_tlast. Inside positions are summed (at most
// sixteen per tile). The rsp_ channel gives one 128-bit mode-6 block per
// tile, bits 0 to 127 of the block in rsp_tdata bits 0 to 127.
// Positions are taken one per cycle while req_tready is high. The tile totals go
// through a queue of QueueDepth entries to a divider that works one quotient
// bit per cycle for all three channels. The back end loads each tile, runs
// 12 divide steps and then emits the block; it takes the next tile from the
// queue only once the block of the last one has gone to the output register.
// When the queue is full, req_tready drops until the divider takes a tile.
// A stalled rsp_ transfer holds its data; the divider then waits with the
// next block finished, and the queue fills behind it.
// Reset clears the sums, empties the queue and drops rsp_tvalid.

module bc7_solid_block_encoder_top #(
   parameter int QueueDepth = bc7e_pkg::QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [23:0]  req_tdata,   // red [7:0], green [15:8], blue [23:16]
   input  logic         req_tuser,   // inside_req
   input  logic         req_tlast,   // tile_end
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata    // block_low [63:0], block_high [127:64]
);
   import bc7e_pkg::*;

   logic          accept;
   logic          push, not_full, not_empty, pop;
   tile_sums_type push_data, pop_data;

   assign req_tready = not_full;
   assign accept     = req_tvalid && req_tready;

   bc7e_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .red        (req_tdata[7:0]),
      .green      (req_tdata[15:8]),
      .blue       (req_tdata[23:16]),
      .inside_req (req_tuser),
      .tile_end   (req_tlast),
      .push       (push),
      .push_data  (push_data)
   );

   bc7e_queue #(
      .QueueDepth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .not_full  (not_full),
      .pop       (pop),
      .not_empty (not_empty),
      .pop_data  (pop_data)
   );

   bc7e_back u_back (
      .clock      (clock),
      .reset      (reset),
      .tile_valid (not_empty),
      .tile_data  (pop_data),
      .tile_pop   (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### rtl/bc7e_front.sv
// Front end: accumulates the inside positions of a tile and hands the totals on.
`timescale 1ns / 1ps

module bc7e_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic [bc7e_pkg::CHAN_W-1:0]  red,
   input  logic [bc7e_pkg::CHAN_W-1:0]  green,
   input  logic [bc7e_pkg::CHAN_W-1:0]  blue,
   input  logic                         inside_req,
   input  logic                         tile_end,
   output logic                         push,
   output bc7e_pkg::tile_sums_type      push_data
);
   import bc7e_pkg::*;

   logic [SUM_W-1:0] red_sum_ff, red_sum_in;
   logic [SUM_W-1:0] green_sum_ff, green_sum_in;
   logic [SUM_W-1:0] blue_sum_ff, blue_sum_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             take;
   tile_sums_type    tile_now;

   // A position counts only while the tile holds fewer than sixteen.
   assign take = inside_req && (count_ff < TILE_POSITIONS);

   // Totals including the position on the port this cycle.
   always_comb begin
      tile_now.red_sum   = take ? red_sum_ff + SUM_W'(red) : red_sum_ff;
      tile_now.green_sum = take ? green_sum_ff + SUM_W'(green) : green_sum_ff;
      tile_now.blue_sum  = take ? blue_sum_ff + SUM_W'(blue) : blue_sum_ff;
      tile_now.count     = take ? count_ff + CNT_W'(1) : count_ff;
   end

   // The last position of a tile sends the totals on and clears them.
   always_comb begin
      red_sum_in   = red_sum_ff;
      green_sum_in = green_sum_ff;
      blue_sum_in  = blue_sum_ff;
      count_in     = count_ff;
      if (accept) begin
         if (tile_end) begin
            red_sum_in   = '0;
            green_sum_in = '0;
            blue_sum_in  = '0;
            count_in     = '0;
         end else begin
            red_sum_in   = tile_now.red_sum;
            green_sum_in = tile_now.green_sum;
            blue_sum_in  = tile_now.blue_sum;
            count_in     = tile_now.count;
         end
      end
   end

   assign push      = accept && tile_end;
   assign push_data = tile_now;

   always_ff @(posedge clock) begin
      if (reset) begin
         red_sum_ff   <= '0;
         green_sum_ff <= '0;
         blue_sum_ff  <= '0;
         count_ff     <= '0;
      end else begin
         red_sum_ff   <= red_sum_in;
         green_sum_ff <= green_sum_in;
         blue_sum_ff  <= blue_sum_in;
         count_ff     <= count_in;
      end
   end

endmodule

### rtl/bc7e_queue.sv
// Short queue of finished tile totals between the front and the back.
`timescale 1ns / 1ps

module bc7e_queue #(
   parameter int QueueDepth = bc7e_pkg::QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  bc7e_pkg::tile_sums_type push_data,
   output logic                    not_full,
   input  logic                    pop,
   output logic                    not_empty,
   output bc7e_pkg::tile_sums_type pop_data
);
   import bc7e_pkg::*;

   localparam int PTR_W = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int FILL_W = $clog2(QueueDepth + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QueueDepth - 1);
   localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(QueueDepth);

   tile_sums_type     slot_ff [QueueDepth];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              do_push, do_pop;

   assign not_full  = (fill_ff != FULL_FILL);
   assign not_empty = (fill_ff != '0);
   assign do_push   = push && not_full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = slot_ff[rd_ptr_ff];

   // Pointers wrap at the queue depth; the fill level follows both ends.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Storage of the queued totals.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/bc7e_back.sv
// Back end: divides the tile sums by the count bit by bit and builds the block.
`timescale 1ns / 1ps

module bc7e_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    tile_valid,
   input  bc7e_pkg::tile_sums_type tile_data,
   output logic                    tile_pop,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [127:0]            rsp_tdata
);
   import bc7e_pkg::*;

   localparam int STEP_W = $clog2(SUM_W);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);
   localparam int LANES = 3;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_DIVIDE,
      BK_EMIT
   } back_state_type;

   back_state_type    state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  divisor_ff, divisor_in;
   logic [SUM_W-1:0]  dvd_ff [LANES];
   logic [SUM_W-1:0]  dvd_in [LANES];
   logic [CNT_W-1:0]  rem_ff [LANES];
   logic [CNT_W-1:0]  rem_in [LANES];
   logic [SUM_W-1:0]  step_dvd [LANES];
   logic [CNT_W-1:0]  step_rem [LANES];
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic [127:0]      rsp_tdata_ff, rsp_tdata_in;
   logic [ENDPOINT_W-1:0] red_ep, green_ep, blue_ep;

   // One restoring step per lane: the quotient bit shifts in behind the dividend.
   for (genvar lane = 0; lane < LANES; lane++) begin : g_lane
      logic [CNT_W:0] rem_shift;
      logic           fits;
      assign rem_shift = {rem_ff[lane], dvd_ff[lane][SUM_W-1]};
      assign fits      = rem_shift >= {1'b0, divisor_ff};
      assign step_rem[lane] = fits ? CNT_W'(rem_shift - {1'b0, divisor_ff})
                                   : rem_shift[CNT_W-1:0];
      assign step_dvd[lane] = {dvd_ff[lane][SUM_W-2:0], fits};
   end

   // The endpoint is the 8-bit average with its low bit forced, shifted down.
   assign red_ep   = dvd_ff[0][CHAN_W-1:1];
   assign green_ep = dvd_ff[1][CHAN_W-1:1];
   assign blue_ep  = dvd_ff[2][CHAN_W-1:1];

   assign tile_pop = (state_ff == BK_IDLE) && tile_valid;

   // Sequencer: load a tile, run the divide, then wait for the output register.
   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      divisor_in    = divisor_ff;
      dvd_in        = dvd_ff;
      rem_in        = rem_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      case (state_ff)
         BK_IDLE: begin
            if (tile_valid) begin
               dvd_in[0]  = tile_data.red_sum;
               dvd_in[1]  = tile_data.green_sum;
               dvd_in[2]  = tile_data.blue_sum;
               rem_in[0]  = '0;
               rem_in[1]  = '0;
               rem_in[2]  = '0;
               divisor_in = (tile_data.count == '0) ? CNT_W'(1) : tile_data.count;
               step_in    = '0;
               state_in   = BK_DIVIDE;
            end
         end
         BK_DIVIDE: begin
            dvd_in  = step_dvd;
            rem_in  = step_rem;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == LAST_STEP) begin
               state_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {63'd0, 1'b1, 1'b1, ALPHA_ENDPOINT, ALPHA_ENDPOINT,
                                blue_ep, blue_ep, green_ep, green_ep,
                                red_ep, red_ep, MODE6_BITS};
               state_in      = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      step_ff      <= step_in;
      divisor_ff   <= divisor_in;
      dvd_ff       <= dvd_in;
      rem_ff       <= rem_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

### rtl/bc7e_checker.sv
// Port-level checks of the encoder, bound to the top level.
`timescale 1ns / 1ps

module bc7e_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata
);

   // A block offered and not taken stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn while stalled");

   // Nothing is offered in the cycle after reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered after reset");

   // Mode bits, alpha, p-bits and indices are fixed in every block.
   a_fixed_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[6:0] == 7'h40) && (rsp_tdata[62:49] == 14'h3FFF)
                     && rsp_tdata[63] && rsp_tdata[64] && (rsp_tdata[127:65] == '0))
      else $error("fixed block field wrong");

   // Both endpoints of each colour are the same.
   a_solid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[13:7] == rsp_tdata[20:14])
                     && (rsp_tdata[27:21] == rsp_tdata[34:28])
                     && (rsp_tdata[41:35] == rsp_tdata[48:42]))
      else $error("endpoints differ");

endmodule

bind bc7_solid_block_encoder_top bc7e_checker u_bc7e_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### verif/bc7_block_checker.sv
// Checker for the BC7 solid block encoder: predicts each block from the input transfers and compares.
`timescale 1ns / 1ps

module bc7_block_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [23:0]  req_tdata,   // red [7:0], green [15:8], blue [23:16]
   input  logic         req_tuser,   // inside_req
   input  logic         req_tlast,   // tile_end
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [127:0] rsp_tdata,   // block_low [63:0], block_high [127:64]
   output int           mismatch_count,
   output int           blocks_outstanding
);

   import bc7e_pkg::*;

   typedef struct {
      logic [63:0] low;
      logic [63:0] high;
   } mode6_block_type;

   // Running totals of the tile being received.
   logic [SUM_W-1:0] red_acc;
   logic [SUM_W-1:0] green_acc;
   logic [SUM_W-1:0] blue_acc;
   logic [CNT_W-1:0] inside_seen;

   // Blocks predicted but not yet seen on the result channel.
   mode6_block_type pending_blocks[$];
   int              blocks_checked;

   initial begin
      mismatch_count     = 0;
      blocks_outstanding = 0;
      blocks_checked     = 0;
   end

   // Average of one channel with the low bit forced, reduced to a 7-bit endpoint.
   function automatic logic [ENDPOINT_W-1:0] endpoint_of(input logic [SUM_W-1:0] sum,
                                                         input logic [CNT_W-1:0] count);
      logic [SUM_W-1:0]  divisor;
      logic [SUM_W-1:0]  quotient;
      logic [CHAN_W-1:0] average;
      divisor  = (count == '0) ? SUM_W'(1) : SUM_W'(count);
      quotient = sum / divisor;
      average  = quotient[CHAN_W-1:0] | CHAN_W'(1);
      return average[CHAN_W-1:1];
   endfunction

   // Mode-6 block with both endpoints at the tile average, opaque alpha and zero indices.
   function automatic mode6_block_type solid_block(input logic [SUM_W-1:0] r_sum,
                                                   input logic [SUM_W-1:0] g_sum,
                                                   input logic [SUM_W-1:0] b_sum,
                                                   input logic [CNT_W-1:0] count);
      mode6_block_type  blk;
      logic [ENDPOINT_W-1:0] r_end;
      logic [ENDPOINT_W-1:0] g_end;
      logic [ENDPOINT_W-1:0] b_end;
      r_end    = endpoint_of(r_sum, count);
      g_end    = endpoint_of(g_sum, count);
      b_end    = endpoint_of(b_sum, count);
      blk.low  = {1'b1, ALPHA_ENDPOINT, ALPHA_ENDPOINT, b_end, b_end, g_end, g_end,
                  r_end, r_end, MODE6_BITS};
      blk.high = 64'd1;
      return blk;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: block %0d: %s", $time, blocks_checked, msg);
      mismatch_count++;
   endtask

   // Watch both channels on every rising edge.
   always @(posedge clock) begin
      mode6_block_type want;
      if (reset) begin
         red_acc     = '0;
         green_acc   = '0;
         blue_acc    = '0;
         inside_seen = '0;
         pending_blocks.delete();
      end else begin
         // A result transfer is compared with the oldest prediction.
         if (rsp_tvalid && rsp_tready) begin
            if (pending_blocks.size() == 0) begin
               report_mismatch($sformatf("unexpected block %h", rsp_tdata));
            end else begin
               want = pending_blocks.pop_front();
               if (rsp_tdata[63:0] !== want.low) begin
                  report_mismatch($sformatf("block_low got %h, expected %h",
                                            rsp_tdata[63:0], want.low));
               end
               if (rsp_tdata[127:64] !== want.high) begin
                  report_mismatch($sformatf("block_high got %h, expected %h",
                                            rsp_tdata[127:64], want.high));
               end
            end
            blocks_checked++;
         end

         // An input transfer updates the totals; the last position yields a block.
         if (req_tvalid && req_tready) begin
            if (req_tuser && inside_seen < TILE_POSITIONS) begin
               red_acc     = red_acc + SUM_W'(req_tdata[7:0]);
               green_acc   = green_acc + SUM_W'(req_tdata[15:8]);
               blue_acc    = blue_acc + SUM_W'(req_tdata[23:16]);
               inside_seen = inside_seen + CNT_W'(1);
            end
            if (req_tlast) begin
               pending_blocks.push_back(solid_block(red_acc, green_acc, blue_acc,
                                                    inside_seen));
               red_acc     = '0;
               green_acc   = '0;
               blue_acc    = '0;
               inside_seen = '0;
            end
         end
      end
      blocks_outstanding <= pending_blocks.size();
   end

endmodule

### verif/tb_top.sv
// Testbench top for the BC7 solid block encoder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

   localparam int RANDOM_ITEMS = 1650;
   localparam int DRAIN_CYCLES = 60;
   localparam int LONG_HOLD    = 500;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [23:0]  req_tdata  = '0;
   logic         req_tuser  = 1'b0;
   logic         req_tlast  = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;

   int mismatch_count;
   int blocks_outstanding;
   int items_sent  = 0;
   int burst_left  = 0;
   int blocks_seen = 0;

   bc7_solid_block_encoder_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   bc7_block_checker checker_i (
      .clock              (clock),
      .reset              (reset),
      .req_tvalid         (req_tvalid),
      .req_tready         (req_tready),
      .req_tdata          (req_tdata),
      .req_tuser          (req_tuser),
      .req_tlast          (req_tlast),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_tready         (rsp_tready),
      .rsp_tdata          (rsp_tdata),
      .mismatch_count     (mismatch_count),
      .blocks_outstanding (blocks_outstanding)
   );

   always #6 clock = ~clock;

   // Safety net against a hung run.
   initial begin
      #3_000_000;
      $display("tb_top failed");
      $finish;
   end

   // Count result transfers so the receiver can time its long hold-offs.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         blocks_seen <= blocks_seen + 1;
      end
   end

   // Receiver: changing stall patterns, plus two long hold-offs that back up the block.
   initial begin : rsp_side
      int hold_left;
      int holds_done;
      int mode;
      int mode_left;
      int cyc;
      hold_left  = 0;
      holds_done = 0;
      mode       = 0;
      mode_left  = 0;
      cyc        = 0;
      forever begin
         @(negedge clock);
         cyc++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if ((holds_done == 0 && blocks_seen >= 10) ||
                      (holds_done == 1 && blocks_seen >= 70)) begin
            holds_done++;
            hold_left = LONG_HOLD;
            rsp_tready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(50, 300);
            end
            mode_left--;
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= $urandom_range(0, 1);
               2: rsp_tready <= (cyc % 7) >= 3;
               default: rsp_tready <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   // Offer one position and hold it until the transfer; gaps fall between bursts.
   task automatic send_position(input logic [7:0] r, input logic [7:0] g,
                                input logic [7:0] b, input logic in_image,
                                input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 5);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {b, g, r};
      req_tuser  <= in_image;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_for_blocks;
      req_tvalid <= 1'b0;
      do @(posedge clock); while (blocks_outstanding != 0);
      @(negedge clock);
   endtask

   initial begin : stimulus
      int          tile_len;
      int          shape;
      int          colour_mode;
      int          crop_w;
      int          crop_h;
      int          tiles;
      int          target;
      logic [7:0]  base_r;
      logic [7:0]  base_g;
      logic [7:0]  base_b;
      logic [7:0]  r;
      logic [7:0]  g;
      logic [7:0]  b;
      logic        in_image;

      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Tile with no inside position: divisor falls back to one.
      send_position(8'($urandom), 8'($urandom), 8'($urandom), 1'b0, 1'b1);
      // Single inside positions at both colour extremes.
      send_position(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1);
      send_position(8'h00, 8'h00, 8'h00, 1'b1, 1'b1);
      // Outside positions around one inside one must not touch the totals.
      send_position(8'hA5, 8'h5A, 8'hC3, 1'b0, 1'b0);
      send_position(8'h12, 8'h34, 8'h56, 1'b1, 1'b0);
      send_position(8'hAB, 8'hCD, 8'hEF, 1'b0, 1'b1);
      // Full tile at maximum, then extra inside positions that must be dropped.
      repeat (16) send_position(8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0);
      send_position(8'h00, 8'h00, 8'h00, 1'b1, 1'b0);
      send_position(8'h00, 8'h00, 8'h00, 1'b1, 1'b1);
      wait_for_blocks();

      // Random tiles: mostly well-formed sixteen-position tiles, some of odd length.
      target = items_sent + RANDOM_ITEMS;
      tiles  = 0;
      while (items_sent < target) begin
         tiles++;
         if (tiles == 60) begin
            wait_for_blocks();
         end
         colour_mode = $urandom_range(0, 2);
         base_r      = 8'($urandom);
         base_g      = 8'($urandom);
         base_b      = 8'($urandom);
         crop_w      = $urandom_range(1, 4);
         crop_h      = $urandom_range(1, 4);
         if ($urandom_range(0, 9) < 8) begin
            tile_len = 16;
            shape    = $urandom_range(0, 7);
         end else begin
            tile_len = $urandom_range(1, 24);
            shape    = 6;
         end
         for (int pos = 0; pos < tile_len; pos++) begin
            case (shape)
               0, 1, 2, 3: in_image = 1'b1;
               4, 5:       in_image = ((pos % 4) < crop_w) && ((pos / 4) < crop_h);
               6:          in_image = $urandom_range(0, 1);
               default:    in_image = 1'b0;
            endcase
            case (colour_mode)
               0: begin
                  r = 8'($urandom);
                  g = 8'($urandom);
                  b = 8'($urandom);
               end
               1: begin
                  r = base_r;
                  g = base_g;
                  b = base_b;
               end
               default: begin
                  r = {8{1'($urandom_range(0, 1))}};
                  g = {8{1'($urandom_range(0, 1))}};
                  b = {8{1'($urandom_range(0, 1))}};
               end
            endcase
            send_position(r, g, b, in_image, pos == tile_len - 1);
         end
      end

      // Let every block come out, then allow for the pipeline to settle.
      wait_for_blocks();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && blocks_outstanding == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

### files.f
rtl/bc7e_pkg.sv
rtl/bc7e_front.sv
rtl/bc7e_queue.sv
rtl/bc7e_back.sv
rtl/bc7_solid_block_encoder_top.sv
rtl/bc7e_checker.sv
verif/bc7_block_checker.sv
verif/tb_top.sv
